@@ rtl/tsc_pkg.sv @@
package tsc_pkg;

    // Working word of the series datapath
    localparam int XW = 64;

    // Defaults for the top-level parameters
    localparam int MAX_TERM_PAIRS_DEF = 32;
    localparam int ACC_FRAC_BITS_DEF  = 40;

    // Term-pair register
    localparam int             TP_W     = 6;
    localparam logic [TP_W-1:0] TP_RESET = 6'd10;

    // Function select codes
    localparam logic FN_SIN = 1'b0;
    localparam logic FN_COS = 1'b1;

    // 360 degrees in Q16.16 and pi/180 in Q36
    localparam logic [31:0] DEG360_Q16  = 32'd23592960;
    localparam logic [31:0] DEG2RAD_Q36 = 32'd1199381129;

    // 1.0 in Q2.30
    localparam logic [XW-1:0] Q30_ONE = 64'd1073741824;

    // Angle reduction: quotient of |angle| / 360 deg fits in this many bits
    localparam int RED_STEPS = 7;

    // Quotient bits produced per divider cycle
    localparam int DIV_BITS = 8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_RAD,
        S_RAD_W,
        S_DIV,
        S_DIV_W,
        S_MUL_W,
        S_PAIR,
        S_ACC,
        S_SQ,
        S_SQ_W,
        S_SQ_ACC,
        S_FIN
    } tsc_state_t;

endpackage

@@ rtl/tsc_mul.sv @@
module tsc_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tsc_pkg::XW-1:0]    op_a,
    input  logic [tsc_pkg::XW-1:0]    op_b,
    output logic                      done,
    output logic [2*tsc_pkg::XW-1:0]  prod
);
    import tsc_pkg::*;

    localparam int HW = XW / 2;

    logic [XW-1:0]   a_reg, a_next;
    logic [XW-1:0]   b_reg, b_next;
    logic [2*XW-1:0] acc_reg, acc_next;
    logic [1:0]      idx_reg, idx_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;

    // One half-width partial product per cycle, summed into the running product
    always_comb
    begin
        logic [HW-1:0]   x;
        logic [HW-1:0]   y;
        logic [XW-1:0]   pp;
        logic [2*XW-1:0] ppx;

        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        idx_next  = idx_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        x   = idx_reg[1] ? a_reg[XW-1:HW] : a_reg[HW-1:0];
        y   = idx_reg[0] ? b_reg[XW-1:HW] : b_reg[HW-1:0];
        pp  = XW'(x) * XW'(y);
        ppx = {{XW{1'b0}}, pp};

        if (start)
        begin
            a_next   = op_a;
            b_next   = op_b;
            acc_next = '0;
            idx_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            unique case (idx_reg)
                2'd0:    acc_next = acc_reg + ppx;
                2'd1,
                2'd2:    acc_next = acc_reg + (ppx << HW);
                default: acc_next = acc_reg + (ppx << XW);
            endcase
            idx_next = idx_reg + 2'd1;
            if (idx_reg == 2'd3)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Operands and running sum
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/tsc_div.sv @@
module tsc_div #(
    parameter int DVW = 9
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [tsc_pkg::XW-1:0] dividend,
    input  logic [DVW-1:0]         divisor,
    output logic                   done,
    output logic [tsc_pkg::XW-1:0] quotient
);
    import tsc_pkg::*;

    localparam int NCYC = XW / DIV_BITS;
    localparam int CW   = $clog2(NCYC);

    logic [XW-1:0]  work_reg, work_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [DVW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           run_reg, run_next;
    logic           done_reg, done_next;

    // Restoring division, DIV_BITS quotient bits per cycle; the quotient
    // shifts in at the low end of the dividend register
    always_comb
    begin
        logic [DVW:0] trial;

        work_next = work_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = '0;

        if (start)
        begin
            work_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            for (int j = 0; j < DIV_BITS; j++)
            begin
                trial     = {rem_next, work_next[XW-1]};
                work_next = {work_next[XW-2:0], 1'b0};
                if (trial >= {1'b0, dvs_reg})
                begin
                    trial        = trial - {1'b0, dvs_reg};
                    work_next[0] = 1'b1;
                end
                rem_next = trial[DVW-1:0];
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(NCYC - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

@@ rtl/taylor_sine_cosine_degrees_unit.sv @@
// Channel   Ports                         Handshake
// --------  ----------------------------  -------------------------------------
// request   func, angle_deg               taken on start high while busy is low
// result    value                         done high for one cycle
// config    term_pairs                    written on term_pairs_we high
//
// P = min(term_pairs, MAX_TERM_PAIRS) is the number of term pairs summed.
// Each series term takes a pass through the radix-256 divider for |x|/k and
// a pass through the four-pass shared multiplier, plus sequencing.
// done pulses in the same cycle as busy falls; a new request may start there.
// Reset clears the sequencer and loads term_pairs with 10. done cannot stall.
module taylor_sine_cosine_degrees_unit #(
    parameter int MAX_TERM_PAIRS = tsc_pkg::MAX_TERM_PAIRS_DEF,
    parameter int ACC_FRAC_BITS  = tsc_pkg::ACC_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic signed [31:0]       angle_deg,
    output logic                     done,
    output logic signed [31:0]       value,
    input  logic                     term_pairs_we,
    input  logic [tsc_pkg::TP_W-1:0] term_pairs
);
    import tsc_pkg::*;

    localparam int KW    = $clog2(4 * MAX_TERM_PAIRS + 3);
    localparam int KPW   = KW - 2;
    localparam int PW    = TP_W + 1;
    localparam int RCW   = $clog2(RED_STEPS);
    localparam int RSH   = (ACC_FRAC_BITS <= 52) ? 52 - ACC_FRAC_BITS : 0;
    localparam int LSH   = (ACC_FRAC_BITS > 52) ? ACC_FRAC_BITS - 52 : 0;
    localparam int OSH_R = (ACC_FRAC_BITS >= 30) ? ACC_FRAC_BITS - 30 : 0;
    localparam int OSH_L = (ACC_FRAC_BITS < 30) ? 30 - ACC_FRAC_BITS : 0;

    localparam logic [XW-1:0] ONE_F   = XW'(1) << ACC_FRAC_BITS;
    localparam logic [XW-1:0] SAT_MAX = {1'b0, {(XW-1){1'b1}}};
    localparam logic [XW-1:0] SAT_MIN = {1'b1, {(XW-1){1'b0}}};

    // (a * b) >> F from the full product, saturating to all ones
    function automatic logic [XW-1:0] mulq(input logic [2*XW-1:0] p);
        if (|p[2*XW-1:XW+ACC_FRAC_BITS])
            return '1;
        return p[XW-1+ACC_FRAC_BITS:ACC_FRAC_BITS];
    endfunction

    // Unsigned magnitude clamped into the signed range
    function automatic logic [XW-1:0] to_sig(input logic [XW-1:0] m);
        return m[XW-1] ? SAT_MAX : m;
    endfunction

    // Signed add, saturating
    function automatic logic [XW-1:0] sat_add(input logic [XW-1:0] a,
                                              input logic [XW-1:0] b);
        logic [XW:0] s;
        s = {a[XW-1], a} + {b[XW-1], b};
        if (s[XW] != s[XW-1])
            return s[XW] ? SAT_MIN : SAT_MAX;
        return s[XW-1:0];
    endfunction

    tsc_state_t      state_reg, state_next;
    logic [TP_W-1:0] tp_reg, tp_next;
    logic            func_reg, func_next;
    logic            neg_reg, neg_next;
    logic [31:0]     rem_reg, rem_next;
    logic [RCW-1:0]  rcnt_reg, rcnt_next;
    logic            pz_reg, pz_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [KW-1:0]   klast_reg, klast_next;
    logic [XW-1:0]   xm_reg, xm_next;
    logic [XW-1:0]   a_reg, a_next;
    logic [XW-1:0]   save_reg, save_next;
    logic [XW-1:0]   diff_reg, diff_next;
    logic [XW-1:0]   acc_reg, acc_next;
    logic [31:0]     value_reg, value_next;
    logic            done_reg, done_next;

    logic            mul_start, mul_done;
    logic [XW-1:0]   mul_a, mul_b;
    logic [2*XW-1:0] mul_prod;
    logic            div_start, div_done;
    logic [XW-1:0]   div_quot;

    tsc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tsc_div #(
        .DVW (KW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (xm_reg),
        .divisor  (k_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer: next state, datapath updates and unit requests
    always_comb
    begin
        logic [PW-1:0]  pairs_c;
        logic [KPW-1:0] pk;
        logic [31:0]    amag;
        logic [31:0]    sub;
        logic [XW-1:0]  newa;
        logic [XW-1:0]  mag64;
        logic [XW-1:0]  m1;
        logic [30:0]    mag31;
        logic [31:0]    sval;
        logic           is_save;
        logic           is_add;
        logic           flip;
        logic           step_end;

        state_next = state_reg;
        tp_next    = tp_reg;
        func_next  = func_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        rcnt_next  = rcnt_reg;
        pz_next    = pz_reg;
        k_next     = k_reg;
        klast_next = klast_reg;
        xm_next    = xm_reg;
        a_next     = a_reg;
        save_next  = save_reg;
        diff_next  = diff_reg;
        acc_next   = acc_reg;
        value_next = value_reg;
        done_next  = 1'b0;

        mul_start  = 1'b0;
        mul_a      = a_reg;
        mul_b      = div_quot;
        div_start  = 1'b0;

        // Pair count, clamped, and the last term index it implies
        pairs_c = ({1'b0, tp_reg} > PW'(MAX_TERM_PAIRS)) ? PW'(MAX_TERM_PAIRS)
                                                           : {1'b0, tp_reg};
        pk      = KPW'(pairs_c);
        amag    = angle_deg[31] ? 32'(-angle_deg) : 32'(angle_deg);
        sub     = DEG360_Q16 << rcnt_reg;
        newa    = mulq(mul_prod);

        // Term k closes a pair (add) or opens one (save)
        if (func_reg == FN_COS)
        begin
            is_save = (k_reg[1:0] == 2'b00);
            is_add  = (k_reg[1:0] == 2'b10) && (k_reg != KW'(2));
        end
        else
        begin
            is_save = (k_reg[1:0] == 2'b01);
            is_add  = (k_reg[1:0] == 2'b11);
        end
        step_end = (k_reg == klast_reg);

        // Output conversion: sine of a negative angle is negated
        flip  = neg_reg && (func_reg == FN_SIN);
        mag64 = acc_reg[XW-1] ? (~acc_reg + XW'(1)) : acc_reg;
        m1    = mag64 >> OSH_R;
        if (m1 > (Q30_ONE >> OSH_L))
            mag31 = 31'(Q30_ONE);
        else
            mag31 = 31'(m1 << OSH_L);
        sval = {1'b0, mag31};

        if (term_pairs_we)
            tp_next = term_pairs;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = func;
                    neg_next   = angle_deg[31];
                    rem_next   = amag;
                    rcnt_next  = RCW'(RED_STEPS - 1);
                    pz_next    = (pairs_c == '0);
                    klast_next = (func == FN_COS) ? {pk, 2'b10}
                                                  : {pk - KPW'(1), 2'b11};
                    state_next = S_REDUCE;
                end
            end

            // |angle| mod 360 degrees, one quotient bit a cycle
            S_REDUCE:
            begin
                if (rem_reg >= sub)
                    rem_next = rem_reg - sub;
                rcnt_next = rcnt_reg - RCW'(1);
                if (rcnt_reg == '0)
                    state_next = S_RAD;
            end

            // Degrees to radians
            S_RAD:
            begin
                mul_start  = 1'b1;
                mul_a      = XW'(rem_reg);
                mul_b      = XW'(DEG2RAD_Q36);
                state_next = S_RAD_W;
            end

            S_RAD_W:
            begin
                if (mul_done)
                begin
                    xm_next  = (mul_prod[XW-1:0] >> RSH) << LSH;
                    a_next   = ONE_F;
                    k_next   = KW'(1);
                    acc_next = '0;
                    if (!pz_reg)
                        state_next = S_DIV;
                    else if (func_reg == FN_COS)
                        state_next = S_SQ;
                    else
                        state_next = S_FIN;
                end
            end

            // Next term: a = (a * (|x| / k)) >> F
            S_DIV:
            begin
                div_start  = 1'b1;
                state_next = S_DIV_W;
            end

            S_DIV_W:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_MUL_W;
                end
            end

            S_MUL_W:
            begin
                if (mul_done)
                begin
                    a_next     = newa;
                    state_next = S_PAIR;
                end
            end

            S_PAIR:
            begin
                if (is_add)
                begin
                    diff_next  = to_sig(save_reg) - to_sig(a_reg);
                    state_next = S_ACC;
                end
                else
                begin
                    if (is_save)
                        save_next = a_reg;
                    k_next     = k_reg + KW'(1);
                    state_next = S_DIV;
                end
            end

            S_ACC:
            begin
                acc_next = sat_add(acc_reg, diff_reg);
                if (step_end)
                    state_next = (func_reg == FN_COS) ? S_SQ : S_FIN;
                else
                begin
                    k_next     = k_reg + KW'(1);
                    state_next = S_DIV;
                end
            end

            // Cosine: add 1 - x^2/2
            S_SQ:
            begin
                mul_start  = 1'b1;
                mul_a      = xm_reg;
                mul_b      = xm_reg;
                state_next = S_SQ_W;
            end

            S_SQ_W:
            begin
                if (mul_done)
                begin
                    diff_next  = ONE_F - (newa >> 1);
                    state_next = S_SQ_ACC;
                end
            end

            S_SQ_ACC:
            begin
                acc_next   = sat_add(acc_reg, diff_reg);
                state_next = S_FIN;
            end

            S_FIN:
            begin
                value_next = (acc_reg[XW-1] ^ flip) ? (32'd0 - sval) : sval;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tp_reg    <= TP_RESET;
            rcnt_reg  <= '0;
            k_reg     <= '0;
            klast_reg <= '0;
            pz_reg    <= 1'b0;
            func_reg  <= FN_SIN;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tp_reg    <= tp_next;
            rcnt_reg  <= rcnt_next;
            k_reg     <= k_next;
            klast_reg <= klast_next;
            pz_reg    <= pz_next;
            func_reg  <= func_next;
            neg_reg   <= neg_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        xm_reg    <= xm_next;
        a_reg     <= a_next;
        save_reg  <= save_next;
        diff_reg  <= diff_next;
        acc_reg   <= acc_next;
        value_reg <= value_next;
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign value = value_reg;

`ifndef SYNTHESIS
    // A request starts the sequencer
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but unit not busy");

    // The sequencer only goes idle by delivering a result
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("unit went idle without a result");

    // Term index never runs past the last term
    a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (k_reg <= klast_reg))
        else $error("term index beyond last term");

    // Result stays within plus or minus one
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((value <= 32'sd1073741824) && (value >= -32'sd1073741824)))
        else $error("result out of range");
`endif

endmodule
